/* src/uart_frame_deframer_unit_macros.svh */
// ----------------------------------------------------------------------------
// uart_frame_deframer_unit assertion macros
// Shared property shorthands for the deframer checkers.
// ----------------------------------------------------------------------------
`ifndef UART_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define UART_FRAME_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define UFD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// next-cycle implication, sampled on clk, off while in reset
`define UFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

/* src/ufd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_pkg
// Types and constants for the UART frame deframer.
// ----------------------------------------------------------------------------
package ufd_pkg;

	localparam int unsigned CFG_INDEX_W = 2;

	// register map
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TIMEOUT = 2'd1;

	localparam logic [15:0] MAX_LENGTH_RESET    = 16'd1536;
	localparam logic [15:0] FRAME_TIMEOUT_RESET = 16'd0;

	localparam logic [7:0] START_BYTE = 8'hAA;
	localparam logic [7:0] END_BYTE   = 8'h55;
	localparam int unsigned START_RUN = 4;
	localparam logic [1:0] START_LAST = 2'(START_RUN - 1);

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	typedef enum logic [1:0] {
		ST_GOOD    = 2'd0,
		ST_BAD_END = 2'd1,
		ST_TIMEOUT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_LEN_LO = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_RSV1   = 3'd3,
		PH_RSV2   = 3'd4,
		PH_DATA   = 3'd5,
		PH_END1   = 3'd6,
		PH_END2   = 3'd7
	} phase_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [15:0] frame_length;
		logic        last;
	} result_t;

endpackage

/* src/uart_frame_deframer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_frame_deframer_unit
// Hunts for 4x 0xAA starts, streams payload bytes, reports frame end status.
// ----------------------------------------------------------------------------
// Takes one byte or tick transaction per clock and returns at most one result
// per transaction, through the input register and then the result register.
// The rate is set by the frame state update between the two registers; a
// stalled result holds the input stage, so an item is taken every cycle while
// results are consumed.
// Registers: 0 max_length (reset 1536), 1 frame_timeout (reset 0, 0 = off).
module uart_frame_deframer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  ufd_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output ufd_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ufd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);

	logic [15:0] max_length_q;
	logic [15:0] frame_timeout_q;

	logic              valid_s1;
	ufd_pkg::item_t    item_s1;

	ufd_pkg::phase_t   phase_q, phase_d;
	logic [1:0]        start_count_q, start_count_d;
	logic [15:0]       decl_len_q, decl_len_d;
	logic [15:0]       pos_q, pos_d;
	logic [15:0]       idle_q, idle_d;

	logic              out_valid_q;
	ufd_pkg::result_t  out_q;

	logic              res_fire;
	ufd_pkg::result_t  res_d;

	logic              out_free;
	logic              s1_go;
	logic [15:0]       idle_inc;
	logic [15:0]       pos_inc;
	logic [15:0]       len_full;
	logic              timeout_hit;

	assign cfg_ready    = 1'b1;
	assign out_free     = !out_valid_q || !result_stall;
	assign s1_go        = valid_s1 && out_free;
	assign item_stall   = valid_s1 && !out_free;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign idle_inc    = (idle_q != ufd_pkg::COUNT_MAX) ? idle_q + 16'd1 : idle_q;
	assign pos_inc     = (pos_q != ufd_pkg::COUNT_MAX) ? pos_q + 16'd1 : pos_q;
	assign len_full    = {item_s1.data_byte, decl_len_q[7:0]};
	assign timeout_hit = (phase_q != ufd_pkg::PH_HUNT) && (frame_timeout_q != 16'd0)
		&& (idle_inc > frame_timeout_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q    <= ufd_pkg::MAX_LENGTH_RESET;
			frame_timeout_q <= ufd_pkg::FRAME_TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ufd_pkg::REG_MAX_LENGTH:    max_length_q    <= cfg_data;
				ufd_pkg::REG_FRAME_TIMEOUT: frame_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// next state
	always_comb begin
		phase_d       = phase_q;
		start_count_d = start_count_q;
		decl_len_d    = decl_len_q;
		pos_d         = pos_q;
		idle_d        = 16'd0;
		if (item_s1.command == ufd_pkg::CMD_TICK) begin
			idle_d = idle_inc;
			if (timeout_hit) begin
				phase_d       = ufd_pkg::PH_HUNT;
				start_count_d = 2'd0;
				pos_d         = 16'd0;
			end
		end else begin
			case (phase_q)
				ufd_pkg::PH_HUNT: begin
					if (item_s1.data_byte == ufd_pkg::START_BYTE) begin
						if (start_count_q == ufd_pkg::START_LAST) begin
							start_count_d = 2'd0;
							decl_len_d    = 16'd0;
							phase_d       = ufd_pkg::PH_LEN_LO;
						end else begin
							start_count_d = start_count_q + 2'd1;
						end
					end else begin
						start_count_d = 2'd0;
					end
				end
				ufd_pkg::PH_LEN_LO: begin
					decl_len_d = {8'd0, item_s1.data_byte};
					phase_d    = ufd_pkg::PH_LEN_HI;
				end
				ufd_pkg::PH_LEN_HI: begin
					decl_len_d = len_full;
					if (len_full > max_length_q) begin
						phase_d       = ufd_pkg::PH_HUNT;
						start_count_d = 2'd0;
					end else begin
						phase_d = ufd_pkg::PH_RSV1;
					end
				end
				ufd_pkg::PH_RSV1: phase_d = ufd_pkg::PH_RSV2;
				ufd_pkg::PH_RSV2: begin
					pos_d   = 16'd0;
					phase_d = ufd_pkg::PH_DATA;
				end
				ufd_pkg::PH_DATA: begin
					pos_d = pos_inc;
					if (pos_inc >= decl_len_q) begin
						phase_d = ufd_pkg::PH_END1;
					end
				end
				ufd_pkg::PH_END1: begin
					if (item_s1.data_byte == ufd_pkg::END_BYTE) begin
						phase_d = ufd_pkg::PH_END2;
					end else begin
						phase_d       = ufd_pkg::PH_HUNT;
						start_count_d = 2'd0;
					end
				end
				default: begin
					phase_d       = ufd_pkg::PH_HUNT;
					start_count_d = 2'd0;
				end
			endcase
		end
	end

	// result
	always_comb begin
		res_fire           = 1'b0;
		res_d.kind         = ufd_pkg::KIND_END;
		res_d.payload_byte = 8'd0;
		res_d.status       = ufd_pkg::ST_GOOD;
		res_d.frame_length = decl_len_q;
		res_d.last         = 1'b1;
		if (item_s1.command == ufd_pkg::CMD_TICK) begin
			if (timeout_hit) begin
				res_fire     = 1'b1;
				res_d.status = ufd_pkg::ST_TIMEOUT;
			end
		end else begin
			case (phase_q)
				ufd_pkg::PH_DATA: begin
					// zero-length frame swallows its one data byte
					if (decl_len_q != 16'd0) begin
						res_fire           = 1'b1;
						res_d.kind         = ufd_pkg::KIND_PAYLOAD;
						res_d.payload_byte = item_s1.data_byte;
						res_d.frame_length = 16'd0;
						res_d.last         = 1'b0;
					end
				end
				ufd_pkg::PH_END1: begin
					if (item_s1.data_byte != ufd_pkg::END_BYTE) begin
						res_fire     = 1'b1;
						res_d.status = ufd_pkg::ST_BAD_END;
					end
				end
				ufd_pkg::PH_END2: begin
					res_fire     = 1'b1;
					res_d.status = (item_s1.data_byte == ufd_pkg::END_BYTE) ?
						ufd_pkg::ST_GOOD : ufd_pkg::ST_BAD_END;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= ufd_pkg::PH_HUNT;
			start_count_q <= 2'd0;
			decl_len_q    <= 16'd0;
			pos_q         <= 16'd0;
			idle_q        <= 16'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (s1_go) begin
				phase_q       <= phase_d;
				start_count_q <= start_count_d;
				decl_len_q    <= decl_len_d;
				pos_q         <= pos_d;
				idle_q        <= idle_d;
			end
			if (out_free) begin
				out_valid_q <= s1_go && res_fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res_fire) begin
			out_q <= res_d;
		end
	end

endmodule

/* src/ufd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_checker
// Port-level checks on the deframer result channel.
// ----------------------------------------------------------------------------
`include "uart_frame_deframer_unit_macros.svh"

module ufd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input ufd_pkg::result_t result
);

	// a stalled transaction holds
	`UFD_ASSERT_NEXT(a_out_hold, result_valid && result_stall, result_valid && $stable(result))

	`UFD_ASSERT_IMPL(a_end_last, result_valid && result.kind == ufd_pkg::KIND_END, result.last)

	`UFD_ASSERT_IMPL(a_payload_clean, result_valid && result.kind == ufd_pkg::KIND_PAYLOAD, !result.last && result.status == ufd_pkg::ST_GOOD && result.frame_length == 16'd0)

	`UFD_ASSERT_IMPL(a_end_no_byte, result_valid && result.kind == ufd_pkg::KIND_END, result.payload_byte == 8'd0)

endmodule

bind uart_frame_deframer_unit ufd_checker u_ufd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
